>>> rtl/hsf_pkg.sv
// Shared constants and types for the heightmap 3x3 smoothing filter.
// No dependencies; every other file but hsf_ram refers to it by scoped names.
package hsf_pkg;

	localparam int MAX_WIDTH       = 1024;
	localparam int SAMPLE_BITS     = 16;
	localparam int HEIGHT_LIMIT    = 4096;
	localparam int COL_BITS        = $clog2(MAX_WIDTH);
	localparam int ROW_BITS        = $clog2(HEIGHT_LIMIT);
	localparam int WREG_BITS       = 11;
	localparam int HREG_BITS       = 13;
	localparam int DATA_BITS       = 32;
	localparam int PADDR_BITS      = 3;

	// nine samples with the centre weighted 4: 12 * max sample
	localparam int SUM_BITS        = SAMPLE_BITS + 4;
	// (sum + 6) >> 2, then divide by 3 via reciprocal multiply
	localparam int QUO_BITS        = SUM_BITS - 2;
	localparam int RECIP_SHIFT     = QUO_BITS + 1;
	localparam int RECIP           = ((1 << RECIP_SHIFT) + 2) / 3;
	localparam int ROUND_BIAS      = 6;

	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS       = QPTR_BITS + 1;

	localparam logic [WREG_BITS-1:0] GRID_WIDTH_RESET  = WREG_BITS'(1024);
	localparam logic [HREG_BITS-1:0] GRID_HEIGHT_RESET = HREG_BITS'(1024);

	// register map index (byte address bit 2)
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		RES_CENTER,
		RES_RIGHT,
		RES_SELF
	} res_t;

	typedef struct packed {
		logic                   restart;
		logic [WREG_BITS-1:0]   grid_width;
		logic [HREG_BITS-1:0]   grid_height;
	} cfg_t;

	// one classified item: up to three results
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] center_val;
		logic [SAMPLE_BITS-1:0] mid_val;
		logic [SAMPLE_BITS-1:0] cur_val;
		logic [COL_BITS-1:0]    col;
		logic [ROW_BITS-1:0]    row;
		logic                   has_center;
		logic                   has_right;
		logic                   has_self;
		logic                   row_end;
	} rec_t;

endpackage

>>> rtl/hsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/hsf_front.sv
// Front end: takes samples, tracks grid position, reads/writes the line stores,
// keeps the 3x3 window and computes the smoothed centre. Uses hsf_pkg, hsf_ram.
module hsf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hsf_pkg::cfg_t                   cfg,
	input  logic                            push,
	output logic                            full,
	input  logic [hsf_pkg::SAMPLE_BITS-1:0] height_sample,
	input  logic [hsf_pkg::QCNT_BITS-1:0]   q_count,
	output logic                            q_push,
	output hsf_pkg::rec_t                   q_rec
);

	localparam int SB = hsf_pkg::SAMPLE_BITS;
	localparam int CB = hsf_pkg::COL_BITS;
	localparam int RB = hsf_pkg::ROW_BITS;
	localparam int WB = hsf_pkg::WREG_BITS;
	localparam int HB = hsf_pkg::HREG_BITS;
	localparam int QB = hsf_pkg::QUO_BITS;
	localparam int PB = QB + hsf_pkg::RECIP_SHIFT;

	// position of the next sample
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	logic [WB-1:0] eff_w, w_max;
	logic [HB-1:0] eff_h, h_max;
	logic [CB-1:0] w_c;
	logic [RB-1:0] h_c;
	logic          w_last, h_last;
	logic          acc;
	logic [hsf_pkg::QCNT_BITS-1:0] occ;

	// stage 1: line store data arrives
	logic          v_s1;
	logic [SB-1:0] x_s1;
	logic [CB-1:0] w_s1;
	logic [RB-1:0] h_s1;
	logic          center_s1, interior_s1, right_s1, self_s1, end_s1;
	logic          fwd_s1;
	logic [SB-1:0] fwd_u_q, fwd_m_q;

	logic [SB-1:0] ram_u, ram_m;
	logic [SB-1:0] u_e, m_e;
	logic [hsf_pkg::SUM_BITS-1:0] sum;

	// window: 0..2 column w-1, 3..5 column w-2 (upper/middle/current)
	logic [SB-1:0] win_q [6];

	// stage 2: divide by 12
	logic          v_s2;
	logic [QB-1:0] quo_s2;
	logic [SB-1:0] pass_s2, m_s2, x_s2;
	logic [CB-1:0] w_s2;
	logic [RB-1:0] h_s2;
	logic          center_s2, interior_s2, right_s2, self_s2, end_s2;
	logic [PB-1:0] prod;

	always_comb begin
		if (cfg.grid_width == '0) begin
			eff_w = WB'(1);
		end else if (cfg.grid_width > WB'(hsf_pkg::MAX_WIDTH)) begin
			eff_w = WB'(hsf_pkg::MAX_WIDTH);
		end else begin
			eff_w = cfg.grid_width;
		end
		if (cfg.grid_height == '0) begin
			eff_h = HB'(1);
		end else if (cfg.grid_height > HB'(hsf_pkg::HEIGHT_LIMIT)) begin
			eff_h = HB'(hsf_pkg::HEIGHT_LIMIT);
		end else begin
			eff_h = cfg.grid_height;
		end
		w_max = eff_w - WB'(1);
		h_max = eff_h - HB'(1);
		w_c = ({1'b0, col_q} >= eff_w) ? w_max[CB-1:0] : col_q;
		h_c = ({1'b0, row_q} >= eff_h) ? h_max[RB-1:0] : row_q;
		w_last = (w_c == w_max[CB-1:0]);
		h_last = (h_c == h_max[RB-1:0]);
	end

	// s1 and s2 never stall, so reserve queue room for them
	assign occ  = q_count + hsf_pkg::QCNT_BITS'(v_s1) + hsf_pkg::QCNT_BITS'(v_s2);
	assign full = (occ >= hsf_pkg::QCNT_BITS'(hsf_pkg::QUEUE_DEPTH));
	assign acc  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg.restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (w_last) begin
				col_q <= '0;
				row_q <= h_last ? '0 : h_c + RB'(1);
			end else begin
				col_q <= w_c + CB'(1);
				row_q <= h_c;
			end
		end
	end

	hsf_ram #(.WIDTH(SB), .DEPTH(hsf_pkg::MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (w_s1),
		.wdata (m_e),
		.raddr (w_c),
		.rdata (ram_u)
	);

	hsf_ram #(.WIDTH(SB), .DEPTH(hsf_pkg::MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (w_s1),
		.wdata (x_s1),
		.raddr (w_c),
		.rdata (ram_m)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= acc;
			// one-column grid: read collides with the write of the item ahead
			fwd_s1 <= acc && v_s1 && (w_c == w_s1);
		end
	end

	always_ff @(posedge clk) begin
		fwd_u_q <= m_e;
		fwd_m_q <= x_s1;
		if (acc) begin
			x_s1        <= height_sample;
			w_s1        <= w_c;
			h_s1        <= h_c;
			center_s1   <= (w_c != '0) && (h_c != '0);
			interior_s1 <= (w_c >= CB'(2)) && (h_c >= RB'(2));
			right_s1    <= w_last && (h_c != '0);
			self_s1     <= h_last;
			end_s1      <= w_last;
		end
	end

	assign u_e = fwd_s1 ? fwd_u_q : ram_u;
	assign m_e = fwd_s1 ? fwd_m_q : ram_m;

	always_comb begin
		sum = hsf_pkg::SUM_BITS'(win_q[3]) + hsf_pkg::SUM_BITS'(win_q[4])
			+ hsf_pkg::SUM_BITS'(win_q[5]) + hsf_pkg::SUM_BITS'(win_q[0])
			+ (hsf_pkg::SUM_BITS'(win_q[1]) << 2)
			+ hsf_pkg::SUM_BITS'(win_q[2]) + hsf_pkg::SUM_BITS'(u_e)
			+ hsf_pkg::SUM_BITS'(m_e) + hsf_pkg::SUM_BITS'(x_s1)
			+ hsf_pkg::SUM_BITS'(hsf_pkg::ROUND_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= u_e;
			win_q[1] <= m_e;
			win_q[2] <= x_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			quo_s2      <= sum[hsf_pkg::SUM_BITS-1:2];
			pass_s2     <= win_q[1];
			m_s2        <= m_e;
			x_s2        <= x_s1;
			w_s2        <= w_s1;
			h_s2        <= h_s1;
			center_s2   <= center_s1;
			interior_s2 <= interior_s1;
			right_s2    <= right_s1;
			self_s2     <= self_s1;
			end_s2      <= end_s1;
		end
	end

	// floor(t / 3) by reciprocal, exact for t below 2^QUO_BITS
	assign prod = PB'(quo_s2) * PB'(hsf_pkg::RECIP);

	always_comb begin
		q_push           = v_s2 && (center_s2 || right_s2 || self_s2);
		q_rec.center_val = interior_s2 ? prod[hsf_pkg::RECIP_SHIFT +: SB] : pass_s2;
		q_rec.mid_val    = m_s2;
		q_rec.cur_val    = x_s2;
		q_rec.col        = w_s2;
		q_rec.row        = h_s2;
		q_rec.has_center = center_s2;
		q_rec.has_right  = right_s2;
		q_rec.has_self   = self_s2;
		q_rec.row_end    = end_s2;
	end

endmodule

>>> rtl/hsf_queue.sv
// Short FIFO of classified items between front and back end.
// Uses hsf_pkg.
module hsf_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr,
	input  hsf_pkg::rec_t                 wdata,
	input  logic                          rd,
	output hsf_pkg::rec_t                 head,
	output logic                          head_valid,
	output logic [hsf_pkg::QCNT_BITS-1:0] count
);

	hsf_pkg::rec_t                 slot_q [hsf_pkg::QUEUE_DEPTH];
	logic [hsf_pkg::QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [hsf_pkg::QCNT_BITS-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + hsf_pkg::QPTR_BITS'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + hsf_pkg::QPTR_BITS'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + hsf_pkg::QCNT_BITS'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - hsf_pkg::QCNT_BITS'(1);
			end
		end
	end

	assign head       = slot_q[rptr_q];
	assign head_valid = (cnt_q != '0);
	assign count      = cnt_q;

endmodule

>>> rtl/hsf_back.sv
// Back end: splits each queued item into its results, one per cycle while the
// output register is empty or popped, and loads them into it. Uses hsf_pkg.
module hsf_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hsf_pkg::rec_t                   head,
	input  logic                            head_valid,
	output logic                            q_pop,
	output logic                            empty,
	input  logic                            pop,
	output logic [hsf_pkg::SAMPLE_BITS-1:0] smoothed_height,
	output logic [hsf_pkg::COL_BITS-1:0]    out_column,
	output logic [hsf_pkg::ROW_BITS-1:0]    out_row,
	output logic                            last_of_item,
	output logic                            grid_done
);

	logic [2:0]            done_q;
	logic [2:0]            pending, sel_bit;
	hsf_pkg::res_t         sel;
	logic                  load, is_last;

	logic                            out_v_q;
	logic [hsf_pkg::SAMPLE_BITS-1:0] val_q, val_n;
	logic [hsf_pkg::COL_BITS-1:0]    col_q, col_n;
	logic [hsf_pkg::ROW_BITS-1:0]    row_q, row_n;
	logic                            last_q, gdone_q, gdone_n;

	assign pending = {head.has_self, head.has_right, head.has_center} & ~done_q;

	always_comb begin
		priority if (pending[0]) begin
			sel     = hsf_pkg::RES_CENTER;
			sel_bit = 3'b001;
		end else if (pending[1]) begin
			sel     = hsf_pkg::RES_RIGHT;
			sel_bit = 3'b010;
		end else begin
			sel     = hsf_pkg::RES_SELF;
			sel_bit = 3'b100;
		end
		is_last = ((pending & ~sel_bit) == 3'b000);
	end

	always_comb begin
		unique case (sel)
			hsf_pkg::RES_CENTER: begin
				val_n   = head.center_val;
				col_n   = head.col - hsf_pkg::COL_BITS'(1);
				row_n   = head.row - hsf_pkg::ROW_BITS'(1);
				gdone_n = 1'b0;
			end
			hsf_pkg::RES_RIGHT: begin
				val_n   = head.mid_val;
				col_n   = head.col;
				row_n   = head.row - hsf_pkg::ROW_BITS'(1);
				gdone_n = 1'b0;
			end
			hsf_pkg::RES_SELF: begin
				val_n   = head.cur_val;
				col_n   = head.col;
				row_n   = head.row;
				gdone_n = head.row_end;
			end
			default: begin
				val_n   = head.cur_val;
				col_n   = head.col;
				row_n   = head.row;
				gdone_n = 1'b0;
			end
		endcase
	end

	assign load  = head_valid && (!out_v_q || pop);
	assign q_pop = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= is_last ? 3'b000 : (done_q | sel_bit);
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q   <= val_n;
			col_q   <= col_n;
			row_q   <= row_n;
			last_q  <= is_last;
			gdone_q <= gdone_n;
		end
	end

	assign empty           = !out_v_q;
	assign smoothed_height = val_q;
	assign out_column      = col_q;
	assign out_row         = row_q;
	assign last_of_item    = last_q;
	assign grid_done       = gdone_q;

endmodule

>>> rtl/heightmap_3x3_smoothing_filter_top.sv
// A sample passes s1, s2, the item queue and the output register; samples enter
// one per cycle unless full, results leave one per cycle when popped, so items
// with two or three results (right edge, last row) hold the input back.
// The output register and the four-entry item queue let input and output stall
// independently. Reset (arst_n low, asynchronous) empties the pipe, zeroes the
// window and position, sets width and height to 1024; line stores are not cleared.
// Top level: APB register block plus front end, item queue and back end.
// Uses hsf_pkg, hsf_front, hsf_queue, hsf_back.
module heightmap_3x3_smoothing_filter_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hsf_pkg::PADDR_BITS-1:0]   paddr,
	input  logic [hsf_pkg::DATA_BITS-1:0]    pwdata,
	output logic [hsf_pkg::DATA_BITS-1:0]    prdata,
	output logic                             pready,
	input  logic                             push,
	output logic                             full,
	input  logic [hsf_pkg::SAMPLE_BITS-1:0]  height_sample,
	output logic                             empty,
	input  logic                             pop,
	output logic [hsf_pkg::SAMPLE_BITS-1:0]  smoothed_height,
	output logic [hsf_pkg::COL_BITS-1:0]     out_column,
	output logic [hsf_pkg::ROW_BITS-1:0]     out_row,
	output logic                             last_of_item,
	output logic                             grid_done
);

	logic [hsf_pkg::WREG_BITS-1:0] grid_width_q;
	logic [hsf_pkg::HREG_BITS-1:0] grid_height_q;
	logic                          reg_idx, wr;
	hsf_pkg::cfg_t                 cfg;

	logic                          q_push, q_pop, head_valid;
	hsf_pkg::rec_t                 q_rec, head;
	logic [hsf_pkg::QCNT_BITS-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_idx = paddr[hsf_pkg::PADDR_BITS-1];
	assign wr      = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hsf_pkg::GRID_WIDTH_RESET;
			grid_height_q <= hsf_pkg::GRID_HEIGHT_RESET;
		end else if (wr) begin
			unique case (reg_idx)
				hsf_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[hsf_pkg::WREG_BITS-1:0];
				hsf_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[hsf_pkg::HREG_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hsf_pkg::REG_GRID_WIDTH:  prdata = hsf_pkg::DATA_BITS'(grid_width_q);
			hsf_pkg::REG_GRID_HEIGHT: prdata = hsf_pkg::DATA_BITS'(grid_height_q);
		endcase
	end

	// any register write restarts at the grid origin
	assign cfg.restart     = wr;
	assign cfg.grid_width  = grid_width_q;
	assign cfg.grid_height = grid_height_q;

	hsf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.push          (push),
		.full          (full),
		.height_sample (height_sample),
		.q_count       (q_count),
		.q_push        (q_push),
		.q_rec         (q_rec)
	);

	hsf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (q_push),
		.wdata      (q_rec),
		.rd         (q_pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	hsf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.head_valid      (head_valid),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.smoothed_height (smoothed_height),
		.out_column      (out_column),
		.out_row         (out_row),
		.last_of_item    (last_of_item),
		.grid_done       (grid_done)
	);

endmodule

>>> rtl/hsf_checker.sv
// Port-level checks on the result side of the filter, bound to the top level.
// Uses hsf_pkg for field widths.
module hsf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            empty,
	input logic                            pop,
	input logic [hsf_pkg::SAMPLE_BITS-1:0] smoothed_height,
	input logic [hsf_pkg::COL_BITS-1:0]    out_column,
	input logic [hsf_pkg::ROW_BITS-1:0]    out_row,
	input logic                            last_of_item,
	input logic                            grid_done
);

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(smoothed_height) && $stable(out_column)
			&& $stable(out_row) && $stable(last_of_item) && $stable(grid_done))
		else $error("waiting result changed before pop");

	// end of grid is always the last result of its sample
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && grid_done |-> last_of_item)
		else $error("grid_done without last_of_item");

	// remaining results of a sample follow at once, left to right
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_item |=> !empty && (out_column >= $past(out_column)))
		else $error("result sequence of one sample broken");

endmodule

bind heightmap_3x3_smoothing_filter_top hsf_checker u_hsf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.smoothed_height (smoothed_height),
	.out_column      (out_column),
	.out_row         (out_row),
	.last_of_item    (last_of_item),
	.grid_done       (grid_done)
);

>>> test/tb_top.sv
// Testbench for the heightmap 3x3 smoothing filter: queue-style sample and result ports,
// APB register port. A local predictor builds the expected result stream that a checker
// compares field by field. Depends on hsf_pkg and heightmap_3x3_smoothing_filter_top.
module tb_top;

	localparam int SAMPLE_BITS  = hsf_pkg::SAMPLE_BITS;
	localparam int COL_BITS     = hsf_pkg::COL_BITS;
	localparam int ROW_BITS     = hsf_pkg::ROW_BITS;
	localparam int WREG_BITS    = hsf_pkg::WREG_BITS;
	localparam int HREG_BITS    = hsf_pkg::HREG_BITS;
	localparam int DATA_BITS    = hsf_pkg::DATA_BITS;
	localparam int PADDR_BITS   = hsf_pkg::PADDR_BITS;
	localparam int MAX_WIDTH    = hsf_pkg::MAX_WIDTH;
	localparam int HEIGHT_LIMIT = hsf_pkg::HEIGHT_LIMIT;

	localparam logic [PADDR_BITS-1:0] ADDR_GRID_WIDTH  = {hsf_pkg::REG_GRID_WIDTH, 2'b00};
	localparam logic [PADDR_BITS-1:0] ADDR_GRID_HEIGHT = {hsf_pkg::REG_GRID_HEIGHT, 2'b00};
	localparam int IDLE_PCT     = 26;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 90;
	localparam int EDGE_ITEMS   = 48;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] height;
		logic [COL_BITS-1:0]    column;
		logic [ROW_BITS-1:0]    row;
		logic                   last;
		logic                   done;
	} grid_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]   pwdata;
	logic [DATA_BITS-1:0]   prdata;
	logic                   pready;
	logic                   push;
	logic                   full;
	logic [SAMPLE_BITS-1:0] height_sample;
	logic                   empty;
	logic                   pop;
	logic [SAMPLE_BITS-1:0] smoothed_height;
	logic [COL_BITS-1:0]    out_column;
	logic [ROW_BITS-1:0]    out_row;
	logic                   last_of_item;
	logic                   grid_done;

	// predictor state
	logic [SAMPLE_BITS-1:0] upper_line [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] middle_line [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] window [6];
	int unsigned            col_pos;
	int unsigned            row_pos;
	logic [WREG_BITS-1:0]   width_reg;
	logic [HREG_BITS-1:0]   height_reg;

	grid_result_t expected_results[$];
	int           error_count;
	int           stall_cycles;
	bit           steady_mode;

	heightmap_3x3_smoothing_filter_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.push(push), .full(full), .height_sample(height_sample),
		.empty(empty), .pop(pop),
		.smoothed_height(smoothed_height), .out_column(out_column), .out_row(out_row),
		.last_of_item(last_of_item), .grid_done(grid_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("heightmap_3x3_smoothing_filter_top verification failed");
		$finish;
	end

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
		return height_reg;
	endfunction

	task automatic clear_filter_state();
		for (int i = 0; i < MAX_WIDTH; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		foreach (window[i]) window[i] = '0;
		col_pos = 0;
		row_pos = 0;
		width_reg = hsf_pkg::GRID_WIDTH_RESET;
		height_reg = hsf_pkg::GRID_HEIGHT_RESET;
	endtask

	// Works out the results one accepted sample causes and advances the raster position.
	task automatic smooth_sample(input logic [SAMPLE_BITS-1:0] x);
		int unsigned wd, ht, w, h, idx, sum, n;
		logic [SAMPLE_BITS-1:0] u, m;
		grid_result_t res [3];
		wd = eff_width();
		ht = eff_height();
		w = col_pos;
		h = row_pos;
		if (w >= wd) w = wd - 1;
		if (h >= ht) h = ht - 1;
		idx = w % MAX_WIDTH;
		u = upper_line[idx];
		m = middle_line[idx];
		n = 0;
		if (w >= 1 && h >= 1) begin
			res[n] = '0;
			res[n].column = COL_BITS'(w - 1);
			res[n].row = ROW_BITS'(h - 1);
			if (w >= 2 && h >= 2) begin
				sum = window[3] + window[4] + window[5] + window[0] + 4 * window[1]
					+ window[2] + u + m + x;
				res[n].height = SAMPLE_BITS'((sum + 6) / 12);
			end else begin
				res[n].height = window[1];
			end
			n++;
		end
		// right edge: the column above the current sample is finished as well
		if (w == wd - 1 && h >= 1) begin
			res[n] = '0;
			res[n].height = m;
			res[n].column = COL_BITS'(wd - 1);
			res[n].row = ROW_BITS'(h - 1);
			n++;
		end
		if (h == ht - 1) begin
			res[n] = '0;
			res[n].height = x;
			res[n].column = COL_BITS'(w);
			res[n].row = ROW_BITS'(h);
			res[n].done = (w == wd - 1);
			n++;
		end
		if (n > 0) res[n - 1].last = 1'b1;
		for (int k = 0; k < n; k++) expected_results.insert(expected_results.size(), res[k]);

		upper_line[idx] = m;
		middle_line[idx] = x;
		window[3] = window[0];
		window[4] = window[1];
		window[5] = window[2];
		window[0] = u;
		window[1] = m;
		window[2] = x;
		if (w + 1 >= wd) begin
			col_pos = 0;
			row_pos = (h + 1 >= ht) ? 0 : h + 1;
		end else begin
			col_pos = w + 1;
			row_pos = h;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		grid_result_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: height %0d column %0d row %0d",
					smoothed_height, out_column, out_row);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (smoothed_height !== exp_r.height) begin
					$error("smoothed_height: expected %0d, actual %0d", exp_r.height,
						smoothed_height);
					error_count++;
				end
				if (out_column !== exp_r.column) begin
					$error("out_column: expected %0d, actual %0d", exp_r.column, out_column);
					error_count++;
				end
				if (out_row !== exp_r.row) begin
					$error("out_row: expected %0d, actual %0d", exp_r.row, out_row);
					error_count++;
				end
				if (last_of_item !== exp_r.last) begin
					$error("last_of_item: expected %0d, actual %0d", exp_r.last, last_of_item);
					error_count++;
				end
				if (grid_done !== exp_r.done) begin
					$error("grid_done: expected %0d, actual %0d", exp_r.done, grid_done);
					error_count++;
				end
			end
		end
	end

	// result receiver: random idling, long hold-offs on request
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				pop = 1'b0;
				stall_cycles--;
			end else if (steady_mode) begin
				pop = 1'b1;
			end else begin
				pop = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic sender_gap();
		if (!steady_mode) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				@(negedge clk);
				push = 1'b0;
				height_sample = SAMPLE_BITS'($urandom);
			end
		end
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		sender_gap();
		@(negedge clk);
		push = 1'b1;
		height_sample = value;
		do @(posedge clk); while (full);
		smooth_sample(value);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		push = 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_BITS-1:0] addr,
			input logic [DATA_BITS-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (addr == ADDR_GRID_WIDTH) width_reg = data[WREG_BITS-1:0];
		else height_reg = data[HREG_BITS-1:0];
		col_pos = 0;
		row_pos = 0;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check_read(input logic [PADDR_BITS-1:0] addr,
			input logic [DATA_BITS-1:0] expected);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== expected) begin
			$error("prdata: expected %0d, actual %0d", expected, prdata);
			error_count++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic configure(input logic [DATA_BITS-1:0] wdata,
			input logic [DATA_BITS-1:0] hdata);
		wait_drained();
		apb_write(ADDR_GRID_WIDTH, wdata);
		apb_write(ADDR_GRID_HEIGHT, hdata);
		apb_check_read(ADDR_GRID_WIDTH, DATA_BITS'(wdata[WREG_BITS-1:0]));
		apb_check_read(ADDR_GRID_HEIGHT, DATA_BITS'(hdata[HREG_BITS-1:0]));
	endtask

	function automatic logic [SAMPLE_BITS-1:0] random_height();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8) return '0;
		if (pick < 16) return '1;
		return SAMPLE_BITS'($urandom);
	endfunction

	task automatic send_random(input int unsigned count);
		for (int unsigned k = 0; k < count; k++) send_sample(random_height());
	endtask

	task automatic test_reset_values();
		apb_check_read(ADDR_GRID_WIDTH, DATA_BITS'(hsf_pkg::GRID_WIDTH_RESET));
		apb_check_read(ADDR_GRID_HEIGHT, DATA_BITS'(hsf_pkg::GRID_HEIGHT_RESET));
	endtask

	task automatic test_smoothing_rules();
		logic [SAMPLE_BITS-1:0] rounding_grid [12];
		// (2,1) sees a neighbour sum of 6 (half rounds up), (1,1) sees 5
		rounding_grid = '{16'd5, 16'd0, 16'd0, 16'd6,
			16'd0, 16'd0, 16'd0, 16'd0,
			16'd0, 16'd0, 16'd0, 16'd0};
		configure(3, 3);
		repeat (9) send_sample('1);
		configure(4, 3);
		foreach (rounding_grid[i]) send_sample(rounding_grid[i]);
		// zero sizes act as one: a single sample is both its own grid and its last row
		configure(0, 0);
		send_sample(16'h5a5a);
		send_sample(16'ha5a5);
	endtask

	task automatic test_grid_extremes();
		// largest width and height, first stretch of the grid only
		configure(MAX_WIDTH, 2);
		send_random(EDGE_ITEMS);
		configure(1, HEIGHT_LIMIT);
		send_random(EDGE_ITEMS);
	endtask

	task automatic test_out_of_range_sizes();
		// partial grids: width clamps to the maximum, height clamps to the limit
		configure(11'h7ff, 3);
		send_random(40);
		configure(2, 13'h1fff);
		send_random(21);
	endtask

	task automatic test_backpressure();
		configure(5, 3);
		steady_mode = 1'b1;
		stall_cycles = 400;
		send_random(45);
		configure(16, 6);
		send_random(96);
		steady_mode = 1'b0;
	endtask

	task automatic test_random_grids();
		int unsigned sent, wraw, hraw, wd, ht, total;
		logic [DATA_BITS-1:0] wdata, hdata;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wraw = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			hraw = $urandom_range(1, 6);
			if ($urandom_range(19) == 0) wraw = 0;
			if ($urandom_range(19) == 0) hraw = 0;
			wdata = DATA_BITS'(wraw);
			hdata = DATA_BITS'(hraw);
			if ($urandom_range(1)) wdata = ($urandom & ~32'h7ff) | wdata;
			if ($urandom_range(1)) hdata = ($urandom & ~32'h1fff) | hdata;
			configure(wdata, hdata);
			wd = eff_width();
			ht = eff_height();
			total = $urandom_range(1, 3) * wd * ht;
			// broken sequence: stop part way and reconfigure
			if ($urandom_range(99) < 15) total = $urandom_range(1, total);
			if (sent + total > RANDOM_ITEMS) total = RANDOM_ITEMS - sent;
			send_random(total);
			sent += total;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		height_sample = '0;
		error_count = 0;
		stall_cycles = 0;
		steady_mode = 1'b0;
		clear_filter_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_smoothing_rules();
		test_out_of_range_sizes();
		test_backpressure();
		test_random_grids();
		test_grid_extremes();

		wait_drained();
		if (error_count == 0) begin
			$display("heightmap_3x3_smoothing_filter_top verification clean");
		end else begin
			$display("heightmap_3x3_smoothing_filter_top verification failed");
		end
		$finish;
	end

endmodule
